@@ src/sncc_pkg.sv @@
package sncc_pkg;

	localparam int HALF    = 3;
	localparam int SPAN    = 2 * HALF + 1;
	localparam int NW      = SPAN * SPAN;
	localparam int MAX_W   = 512;
	localparam int MAX_H   = 512;
	localparam int MAX_S   = 64;
	localparam int LAG_MAX = HALF * MAX_W + HALF + MAX_S - 1;
	localparam int RING    = 2 * LAG_MAX + 2;
	localparam int AW      = $clog2(RING);

	localparam logic signed [14:0] RING_S = 15'(RING);

	typedef logic [AW-1:0] addr_t;

	typedef struct packed {
		logic [9:0] width;
		logic [9:0] height;
		logic [6:0] range;
		logic       side;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CAND,
		ST_ACC,
		ST_DRAIN,
		ST_MUL,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [3:0] {
		MS_SQA,
		MS_SQB,
		MS_AB,
		MS_CABS,
		MS_SQC,
		MS_VAVB,
		MS_DEN,
		MS_X0,
		MS_X1,
		MS_X2,
		MS_X3,
		MS_Y0,
		MS_Y1,
		MS_Y2,
		MS_Y3,
		MS_CMP
	} mstep_t;

	typedef struct packed {
		logic   accept;
		logic   start;
		logic   cand_next;
		logic   tap_clear;
		logic   tap_issue;
		logic   mul_en;
		mstep_t step;
		logic   load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic emit_req;
		logic interior;
		logic cand_ok;
		logic cand_end;
		logic tap_last;
		logic out_full;
	} dp_stat_t;

	function automatic addr_t ring_wrap(input logic signed [14:0] x);
		logic signed [14:0] y;
		if (x < 15'sd0) y = x + RING_S;
		else if (x >= RING_S) y = x - RING_S;
		else y = x;
		return y[AW-1:0];
	endfunction

endpackage

@@ src/sncc_ctrl.sv @@
module sncc_ctrl
	import sncc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_d;
	mstep_t     step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MS_SQA;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE:  if (stat.emit_req) state_d = ST_START;
			ST_START: state_d = stat.interior ? ST_CAND : ST_DONE;
			ST_CAND: begin
				if (stat.cand_end) state_d = ST_DONE;
				else if (stat.cand_ok) state_d = ST_ACC;
			end
			ST_ACC:   if (stat.tap_last) state_d = ST_DRAIN;
			ST_DRAIN: begin
				state_d = ST_MUL;
				step_d  = MS_SQA;
			end
			ST_MUL: begin
				if (step_q == MS_CMP) state_d = ST_CAND;
				else step_d = mstep_t'(step_q + 4'd1);
			end
			ST_DONE:  if (!stat.out_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = stat.emit_req;
				cmd.accept = in_valid & ~stat.emit_req;
			end
			ST_START: cmd.start = 1'b1;
			ST_CAND: begin
				if (!stat.cand_end) begin
					if (stat.cand_ok) cmd.tap_clear = 1'b1;
					else cmd.cand_next = 1'b1;
				end
			end
			ST_ACC:   cmd.tap_issue = 1'b1;
			ST_DRAIN: cmd.mul_en = 1'b0;
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == MS_CMP) cmd.cand_next = 1'b1;
			end
			ST_DONE:  cmd.load_out = ~stat.out_full;
			default:  cmd = '0;
		endcase
	end

endmodule

@@ src/sncc_datapath.sv @@
module sncc_datapath
	import sncc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  ctl_cmd_t   cmd,
	input  logic [7:0] first_pixel,
	input  logic [7:0] second_pixel,
	input  logic       pad_item,
	output dp_stat_t   stat,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [5:0] disparity,
	output logic [8:0] pixel_column,
	output logic [8:0] pixel_row,
	output logic       frame_last
);

	logic [15:0] mem [RING];
	logic [15:0] rda_s1, rdb_s1;
	logic        rd_valid_s1;

	addr_t       wr_slot_q, base_q;
	logic [11:0] pending_q;
	logic [8:0]  in_col_q, in_row_q, out_col_q, out_row_q;
	logic        emit_req_q;
	logic [6:0]  i_q;
	logic [2:0]  dr_q, dc_q;
	logic signed [12:0] roff_q;

	logic [13:0] sa_q, sb_q;
	logic [21:0] saa_q, sbb_q, sab_q;

	logic [27:0]  va_q, vb_q, cabs_q, mul_a, mul_b;
	logic [55:0]  p_s1, num_q, den_q, bn_q, bd_q;
	logic [111:0] acc_q, x_q, y_c;
	logic [5:0]   best_d_q;

	logic        out_valid_q, frame_last_q;
	logic [5:0]  disp_q;
	logic [8:0]  ocol_q, orow_q;

	logic [11:0] lag_c, pend_inc;
	addr_t       wr_next, base_c, addr_a, addr_b;
	logic        in_col_end, in_row_end, out_col_end, out_row_end, out_last;
	logic signed [3:0]  dcoff;
	logic signed [7:0]  shift_c;
	logic signed [14:0] raw_a, raw_b;
	logic [7:0]  pa, pb;
	logic [27:0] nw_saa, nw_sbb, nw_sab;
	logic signed [28:0] c_c;
	logic        beat;

	// lag in pixels before the oldest pending one can be scored
	assign lag_c    = 12'({cfg.width, 1'b0}) + 12'(cfg.width) + 12'(cfg.range) + 12'd2;
	assign pend_inc = pending_q + 12'd1;
	assign wr_next  = (wr_slot_q == AW'(RING - 1)) ? '0 : wr_slot_q + 1'b1;
	assign base_c   = (12'(wr_slot_q) >= pending_q) ? AW'(12'(wr_slot_q) - pending_q)
		: AW'(13'(wr_slot_q) + 13'(RING) - 13'(pending_q));

	assign in_col_end  = (10'(in_col_q) + 10'd1) >= cfg.width;
	assign in_row_end  = (10'(in_row_q) + 10'd1) >= cfg.height;
	assign out_col_end = (10'(out_col_q) + 10'd1) >= cfg.width;
	assign out_row_end = (10'(out_row_q) + 10'd1) >= cfg.height;
	assign out_last    = out_col_end & out_row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q  <= '0;
			pending_q  <= '0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			emit_req_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (pad_item) begin
					emit_req_q <= (in_col_q == '0) && (in_row_q == '0) && (pending_q != '0);
				end else begin
					wr_slot_q  <= wr_next;
					pending_q  <= pend_inc;
					emit_req_q <= pend_inc > lag_c;
					if (in_col_end) begin
						in_col_q <= '0;
						in_row_q <= in_row_end ? '0 : in_row_q + 9'd1;
					end else begin
						in_col_q <= in_col_q + 9'd1;
					end
				end
			end else if (cmd.start) begin
				emit_req_q <= 1'b0;
			end
			if (cmd.load_out) begin
				pending_q <= pending_q - 12'd1;
				if (out_last) begin
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 9'd1;
				end else begin
					out_col_q <= out_col_q + 9'd1;
				end
			end
		end
	end

	// window taps
	assign dcoff   = $signed({1'b0, dc_q}) - 4'sd3;
	assign shift_c = cfg.side ? -$signed({1'b0, i_q}) : $signed({1'b0, i_q});
	assign raw_a   = $signed({3'b000, base_q}) + 15'(roff_q) + 15'(dcoff);
	assign raw_b   = raw_a + 15'(shift_c);
	assign addr_a  = ring_wrap(raw_a);
	assign addr_b  = ring_wrap(raw_b);

	always_ff @(posedge clk) begin
		if (cmd.accept && !pad_item) mem[wr_slot_q] <= {second_pixel, first_pixel};
		rda_s1 <= mem[addr_a];
		rdb_s1 <= mem[addr_b];
	end

	assign pa = cfg.side ? rda_s1[15:8] : rda_s1[7:0];
	assign pb = cfg.side ? rdb_s1[7:0] : rdb_s1[15:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_valid_s1 <= 1'b0;
		else rd_valid_s1 <= cmd.tap_issue;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			base_q <= base_c;
			i_q    <= '0;
		end else if (cmd.cand_next) begin
			i_q <= i_q + 7'd1;
		end
		if (cmd.tap_clear) begin
			dr_q   <= '0;
			dc_q   <= '0;
			roff_q <= 13'sd0 - $signed(13'({cfg.width, 1'b0})) - $signed(13'(cfg.width));
			sa_q   <= '0;
			sb_q   <= '0;
			saa_q  <= '0;
			sbb_q  <= '0;
			sab_q  <= '0;
		end else begin
			if (cmd.tap_issue) begin
				if (dc_q == 3'(SPAN - 1)) begin
					dc_q   <= '0;
					dr_q   <= dr_q + 3'd1;
					roff_q <= roff_q + $signed(13'(cfg.width));
				end else begin
					dc_q <= dc_q + 3'd1;
				end
			end
			if (rd_valid_s1) begin
				sa_q  <= sa_q + 14'(pa);
				sb_q  <= sb_q + 14'(pb);
				saa_q <= saa_q + 22'(pa * pa);
				sbb_q <= sbb_q + 22'(pb * pb);
				sab_q <= sab_q + 22'(pa * pb);
			end
		end
	end

	// shared multiplier, one partial product per step
	assign nw_saa = 28'(saa_q) * 28'(NW);
	assign nw_sbb = 28'(sbb_q) * 28'(NW);
	assign nw_sab = 28'(sab_q) * 28'(NW);
	assign c_c    = $signed({1'b0, nw_sab}) - $signed({1'b0, p_s1[27:0]});
	assign y_c    = acc_q + (112'(p_s1) << 56);
	assign beat   = (va_q != '0) && (vb_q != '0) && (x_q > y_c);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.step)
			MS_SQA:  begin mul_a = 28'(sa_q); mul_b = 28'(sa_q); end
			MS_SQB:  begin mul_a = 28'(sb_q); mul_b = 28'(sb_q); end
			MS_AB:   begin mul_a = 28'(sa_q); mul_b = 28'(sb_q); end
			MS_SQC:  begin mul_a = cabs_q; mul_b = cabs_q; end
			MS_VAVB: begin mul_a = va_q; mul_b = vb_q; end
			MS_X0:   begin mul_a = num_q[27:0]; mul_b = bd_q[27:0]; end
			MS_X1:   begin mul_a = num_q[27:0]; mul_b = bd_q[55:28]; end
			MS_X2:   begin mul_a = num_q[55:28]; mul_b = bd_q[27:0]; end
			MS_X3:   begin mul_a = num_q[55:28]; mul_b = bd_q[55:28]; end
			MS_Y0:   begin mul_a = bn_q[27:0]; mul_b = den_q[27:0]; end
			MS_Y1:   begin mul_a = bn_q[27:0]; mul_b = den_q[55:28]; end
			MS_Y2:   begin mul_a = bn_q[55:28]; mul_b = den_q[27:0]; end
			MS_Y3:   begin mul_a = bn_q[55:28]; mul_b = den_q[55:28]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bn_q     <= '0;
			bd_q     <= 56'd1;
			best_d_q <= '0;
		end
		if (cmd.mul_en) begin
			case (cmd.step)
				MS_SQB:  va_q <= nw_saa - p_s1[27:0];
				MS_AB:   vb_q <= nw_sbb - p_s1[27:0];
				MS_CABS: cabs_q <= c_c[28] ? 28'(-c_c) : 28'(c_c);
				MS_VAVB: num_q <= p_s1;
				MS_DEN:  den_q <= p_s1;
				MS_X1:   acc_q <= 112'(p_s1);
				MS_X2:   acc_q <= acc_q + (112'(p_s1) << 28);
				MS_X3:   acc_q <= acc_q + (112'(p_s1) << 28);
				MS_Y0:   x_q <= acc_q + (112'(p_s1) << 56);
				MS_Y1:   acc_q <= 112'(p_s1);
				MS_Y2:   acc_q <= acc_q + (112'(p_s1) << 28);
				MS_Y3:   acc_q <= acc_q + (112'(p_s1) << 28);
				MS_CMP: begin
					if (beat) begin
						bn_q     <= num_q;
						bd_q     <= den_q;
						best_d_q <= i_q[5:0];
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			disp_q       <= best_d_q;
			ocol_q       <= out_col_q;
			orow_q       <= out_row_q;
			frame_last_q <= out_last;
		end
	end

	assign stat.emit_req = emit_req_q;
	assign stat.interior = (out_row_q >= 9'(HALF)) && ((10'(out_row_q) + 10'(HALF)) < cfg.height)
		&& (out_col_q >= 9'(HALF)) && ((10'(out_col_q) + 10'(HALF)) < cfg.width);
	assign stat.cand_ok  = cfg.side ? (10'(out_col_q) >= (10'(i_q) + 10'(HALF)))
		: ((11'(out_col_q) + 11'(i_q) + 11'(HALF)) < 11'(cfg.width));
	assign stat.cand_end = i_q >= cfg.range;
	assign stat.tap_last = (dr_q == 3'(SPAN - 1)) && (dc_q == 3'(SPAN - 1));
	assign stat.out_full = out_valid_q;

	assign out_valid    = out_valid_q;
	assign disparity    = disp_q;
	assign pixel_column = ocol_q;
	assign pixel_row    = orow_q;
	assign frame_last   = frame_last_q;

endmodule

@@ src/stereo_ncc_disparity_search.sv @@
// latency: an item that completes a window is answered once its candidate search ends; a
//   candidate reaching past the image border is skipped, and a border pixel gets no search
// throughput: items with no result pass without a stall; an item with a result stalls
//   the input through its search, set by the 49 tap reads per candidate and 16 steps of
//   the shared 28x28 multiplier, longer while a finished result waits in the result register on out_stall
// reset: arst_n clears control, stream counters, configuration registers and the output valid flag at once;
//   the line store is not cleared and needs no clearing pass
module stereo_ncc_disparity_search
	import sncc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  first_pixel,
	input  logic [7:0]  second_pixel,
	input  logic        pad_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  disparity,
	output logic [8:0]  pixel_column,
	output logic [8:0]  pixel_row,
	output logic        frame_last
);

	// register indexes on paddr[3:2]
	localparam logic [1:0] REG_RANGE  = 2'd0;
	localparam logic [1:0] REG_SIDE   = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	logic [6:0] cand_count_q;
	logic       reference_side_q;
	logic [9:0] image_width_q, image_height_q;
	logic       cfg_wr;
	cfg_t       cfg;
	ctl_cmd_t   cmd;
	dp_stat_t   stat;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// apb write transfer lands in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_count_q     <= 7'd60;
			reference_side_q <= 1'b0;
			image_width_q    <= 10'd427;
			image_height_q   <= 10'd370;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_RANGE:  cand_count_q     <= pwdata[6:0];
				REG_SIDE:   reference_side_q <= pwdata[0];
				REG_WIDTH:  image_width_q    <= pwdata[9:0];
				REG_HEIGHT: image_height_q   <= pwdata[9:0];
				default:    cand_count_q     <= cand_count_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RANGE:  prdata = 32'(cand_count_q);
			REG_SIDE:   prdata = 32'(reference_side_q);
			REG_WIDTH:  prdata = 32'(image_width_q);
			REG_HEIGHT: prdata = 32'(image_height_q);
			default:    prdata = '0;
		endcase
	end

	// saturate registers to the supported range
	always_comb begin
		cfg.side = reference_side_q;
		if (image_width_q == '0) cfg.width = 10'd1;
		else if (image_width_q > 10'(MAX_W)) cfg.width = 10'(MAX_W);
		else cfg.width = image_width_q;
		if (image_height_q == '0) cfg.height = 10'd1;
		else if (image_height_q > 10'(MAX_H)) cfg.height = 10'(MAX_H);
		else cfg.height = image_height_q;
		if (cand_count_q == '0) cfg.range = 7'd1;
		else if (cand_count_q > 7'(MAX_S)) cfg.range = 7'(MAX_S);
		else cfg.range = cand_count_q;
	end

	// sequencer: candidate loop, tap reads, multiply steps
	sncc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// line store, window sums, score compare and result register
	sncc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.first_pixel  (first_pixel),
		.second_pixel (second_pixel),
		.pad_item     (pad_item),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.disparity    (disparity),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.frame_last   (frame_last)
	);

endmodule

@@ src/sncc_checker.sv @@
module sncc_checker
	import sncc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] disparity,
	input logic [8:0] pixel_column,
	input logic [8:0] pixel_row,
	input logic       frame_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(disparity)
			&& $stable(pixel_column) && $stable(pixel_row) && $stable(frame_last))
		else $error("stalled result changed");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded while input open");

	a_col_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_column < 9'(HALF)) |-> disparity == 6'd0)
		else $error("border column with nonzero disparity");

	a_row_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_row < 9'(HALF)) |-> disparity == 6'd0)
		else $error("border row with nonzero disparity");

endmodule

bind stereo_ncc_disparity_search sncc_checker u_chk (.*);

@@ sim/tb.sv @@
module tb;
	import sncc_pkg::*;

	// register indexes of the configuration port
	typedef enum int {
		REG_RANGE  = 0,
		REG_SIDE   = 1,
		REG_WIDTH  = 2,
		REG_HEIGHT = 3
	} reg_idx_t;

	// picture content of one frame
	typedef enum int {
		PAT_FLAT,
		PAT_EXTREME,
		PAT_SHIFT,
		PAT_NOISE,
		PAT_PADMID
	} pattern_t;

	// one result of the block
	typedef struct {
		logic [5:0] disp;
		logic [8:0] col;
		logic [8:0] row;
		logic       last;
	} match_t;

	// one row of the directed table: settings plus frame content
	typedef struct {
		int       range;
		int       side;
		int       width;
		int       height;
		int       frames;
		pattern_t pat;
	} frame_plan_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  first_pixel;
	logic [7:0]  second_pixel;
	logic        pad_item;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  disparity;
	logic [8:0]  pixel_column;
	logic [8:0]  pixel_row;
	logic        frame_last;

	stereo_ncc_disparity_search DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_pixel  (first_pixel),
		.second_pixel (second_pixel),
		.pad_item     (pad_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.disparity    (disparity),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.frame_last   (frame_last)
	);

	// clock, period 4
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mirror of the block's registers, raw as written
	int unsigned mir_range;
	int unsigned mir_side;
	int unsigned mir_width;
	int unsigned mir_height;

	// mirror of the line store and stream positions
	logic [15:0] line_ring [RING];
	int          wr_pos;
	int          pend_cnt;
	int          in_col;
	int          in_row;
	int          out_idx;

	match_t      match_q [$];

	int          fail_cnt;
	int          items_sent;
	int          pads_sent;
	int          results_seen;
	int          nonzero_seen;
	int          phase_cnt;

	// sender pacing
	int          burst_left;
	bit          steady_feed;

	// receiver pacing
	int          stall_mode;
	bit          hold_req;

	// saturate a register to 1..top
	function automatic int unsigned clamp_reg(int unsigned v, int unsigned top);
		if (v == 0)
			return 1;
		return (v > top) ? top : v;
	endfunction

	// one gray level out of the line store, relative to a window center
	function automatic logic [7:0] ring_byte(int base, int off, bit upper);
		int k;
		k = (base + off + RING) % RING;
		return upper ? line_ring[k][15:8] : line_ring[k][7:0];
	endfunction

	// scores the candidates of the oldest pending pixel and queues its result
	task automatic score_oldest();
		int unsigned w, h, s;
		int base, row, col, i, dr, dc, off, shift;
		bit last;
		bit ref_hi;
		longint unsigned sa, sb, saa, sbb, sab, va, vb, num, den, top_num, top_den;
		longint unsigned a, b;
		longint signed cov;
		logic [127:0] lhs, rhs;
		logic [5:0] top_disp;
		match_t m;
		w = clamp_reg(mir_width, MAX_W);
		h = clamp_reg(mir_height, MAX_H);
		s = clamp_reg(mir_range, MAX_S);
		base = (wr_pos + RING - pend_cnt) % RING;
		row = out_idx / w;
		col = out_idx % w;
		last = (out_idx + 1 >= w * h);
		ref_hi = (mir_side != 0);
		top_num = 0;
		top_den = 1;
		top_disp = '0;
		// border pixels keep disparity 0
		if (row >= HALF && row + HALF < h && col >= HALF && col + HALF < w) begin
			for (i = 0; i < s; i++) begin
				// candidate window must lie wholly inside the image
				if (!ref_hi) begin
					if (col + i + HALF >= w)
						continue;
					shift = i;
				end else begin
					if (col < i + HALF)
						continue;
					shift = -i;
				end
				sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
				for (dr = -HALF; dr <= HALF; dr++) begin
					for (dc = -HALF; dc <= HALF; dc++) begin
						off = dr * int'(w) + dc;
						a = ring_byte(base, off, ref_hi);
						b = ring_byte(base, off + shift, !ref_hi);
						sa += a;
						sb += b;
						saa += a * a;
						sbb += b * b;
						sab += a * b;
					end
				end
				va = NW * saa - sa * sa;
				vb = NW * sbb - sb * sb;
				// flat window on either side: no score
				if (va == 0 || vb == 0)
					continue;
				cov = longint'(NW * sab) - longint'(sa * sb);
				if (cov < 0)
					cov = -cov;
				num = longint'(cov) * longint'(cov);
				den = va * vb;
				// strict compare, so the smallest disparity keeps a tie
				lhs = {64'd0, num} * {64'd0, top_den};
				rhs = {64'd0, top_num} * {64'd0, den};
				if (lhs > rhs) begin
					top_num = num;
					top_den = den;
					top_disp = i[5:0];
				end
			end
		end
		m.disp = top_disp;
		m.col = col[8:0];
		m.row = row[8:0];
		m.last = last;
		match_q.push_back(m);
		pend_cnt--;
		out_idx = last ? 0 : out_idx + 1;
	endtask

	// updates the mirror for one accepted transfer
	task automatic absorb_item(logic [7:0] fp, logic [7:0] sp, logic pad);
		int unsigned w, h, lag;
		w = clamp_reg(mir_width, MAX_W);
		h = clamp_reg(mir_height, MAX_H);
		lag = HALF * w + HALF + clamp_reg(mir_range, MAX_S) - 1;
		if (pad) begin
			// a pad only flushes when the stream sits at a frame start
			if (in_row == 0 && in_col == 0 && pend_cnt > 0)
				score_oldest();
			return;
		end
		line_ring[wr_pos] = {sp, fp};
		wr_pos = (wr_pos + 1) % RING;
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
		end else begin
			in_col++;
		end
		pend_cnt++;
		if (pend_cnt > lag)
			score_oldest();
	endtask

	// offers one transfer, waits for it to be taken, then predicts
	task automatic send_item(logic [7:0] fp, logic [7:0] sp, logic pad);
		if (!steady_feed && burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end else begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		first_pixel <= fp;
		second_pixel <= sp;
		pad_item <= pad;
		do
			@(posedge clk);
		while (in_stall);
		absorb_item(fp, sp, pad);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
		if (pad)
			pads_sent++;
	endtask

	task automatic stop_feed();
		@(negedge clk);
		in_valid <= 1'b0;
		pad_item <= 1'b0;
	endtask

	task automatic reg_write(reg_idx_t idx, int unsigned val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(4 * idx);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RANGE: begin
				mir_range = val & 32'h7F;
			end
			REG_SIDE: begin
				mir_side = val & 32'h1;
			end
			REG_WIDTH: begin
				mir_width = val & 32'h3FF;
			end
			REG_HEIGHT: begin
				mir_height = val & 32'h3FF;
			end
		endcase
	endtask

	// reads a register back and compares it with what is expected there
	task automatic reg_check(reg_idx_t idx, int unsigned want, int unsigned mask);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'(4 * idx);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if ((got & mask) != want) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("register %s reads %0d, expected %0d", idx.name(), got & mask, want);
		end
	endtask

	// waits for every queued result, then lets the block settle
	task automatic wait_idle();
		while (match_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// one frame of pixels, built from the chosen content
	task automatic run_frame(pattern_t pat);
		int unsigned w, h, s, d;
		int r, c, src;
		logic [7:0] base_row [0:1023];
		logic [7:0] fp, sp;
		w = clamp_reg(mir_width, MAX_W);
		h = clamp_reg(mir_height, MAX_H);
		s = clamp_reg(mir_range, MAX_S);
		d = $urandom_range(0, (s < w ? s : w) - 1);
		for (r = 0; r < h; r++) begin
			for (c = 0; c < 1024; c++)
				base_row[c] = 8'($urandom_range(0, 255));
			for (c = 0; c < w; c++) begin
				case (pat)
					PAT_FLAT: begin
						fp = 8'd200;
						sp = 8'd17;
					end
					PAT_EXTREME: begin
						fp = ((r + c) % 2) ? 8'd255 : 8'd0;
						sp = ((r + c) % 2) ? 8'd0 : 8'd255;
					end
					PAT_NOISE: begin
						fp = 8'($urandom_range(0, 255));
						sp = 8'($urandom_range(0, 255));
					end
					default: begin
						// the candidate image is the reference moved by d columns
						if (mir_side == 0) begin
							fp = base_row[c];
							src = c - int'(d);
							sp = (src >= 0) ? base_row[src] : 8'($urandom_range(0, 255));
						end else begin
							sp = base_row[c];
							src = c + int'(d);
							fp = (src < w) ? base_row[src] : 8'($urandom_range(0, 255));
						end
						// a little disagreement between the two images
						if ($urandom_range(0, 15) == 0)
							fp = 8'($urandom_range(0, 255));
					end
				endcase
				// stray pads inside the frame are ignored by the block
				if (pat == PAT_PADMID && (r != 0 || c != 0) && $urandom_range(0, 5) == 0)
					send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
				send_item(fp, sp, 1'b0);
			end
		end
	endtask

	// settings while idle, whole frames back to back, then pads to flush the rest
	task automatic run_phase(frame_plan_t fp_plan);
		int k;
		wait_idle();
		reg_write(REG_RANGE, fp_plan.range);
		reg_write(REG_SIDE, fp_plan.side);
		reg_write(REG_WIDTH, fp_plan.width);
		reg_write(REG_HEIGHT, fp_plan.height);
		for (k = 0; k < fp_plan.frames; k++)
			run_frame(fp_plan.pat);
		while (pend_cnt > 0)
			send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
		stop_feed();
		phase_cnt++;
	endtask

	// directed settings: flat and extreme pictures, both search sides, range
	// saturation at both ends, size saturation at the low end, stray pads and
	// frames back to back
	frame_plan_t plan_table [] = '{
		'{4,   0, 7,    7,    1, PAT_FLAT},
		'{4,   0, 7,    7,    1, PAT_EXTREME},
		'{8,   0, 12,   8,    1, PAT_SHIFT},
		'{8,   1, 12,   8,    1, PAT_SHIFT},
		'{64,  0, 7,    7,    1, PAT_NOISE},
		'{127, 1, 9,    7,    1, PAT_NOISE},
		'{0,   0, 8,    7,    1, PAT_NOISE},
		'{1,   0, 12,   0,    1, PAT_NOISE},
		'{1,   1, 0,    9,    1, PAT_NOISE},
		'{5,   1, 7,    7,    2, PAT_PADMID}
	};

	// result checker: each transfer out against the oldest expectation
	always @(posedge clk) begin
		match_t m;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (disparity != 0)
				nonzero_seen++;
			if (match_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected result: disp %0d col %0d row %0d last %0d",
						disparity, pixel_column, pixel_row, frame_last);
			end else begin
				m = match_q.pop_front();
				if (disparity !== m.disp || pixel_column !== m.col || pixel_row !== m.row
						|| frame_last !== m.last) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: got disp %0d col %0d row %0d last %0d, exp %0d %0d %0d %0d",
							disparity, pixel_column, pixel_row, frame_last,
							m.disp, m.col, m.row, m.last);
				end
			end
		end
	end

	// receiver: a stall pattern per phase, plus one long hold-off on request
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				// long hold-off so the block fills and stalls its input
				out_stall <= 1'b1;
				repeat (600) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ((cyc % 11) < 4);
				endcase
			end
		end
	end

	// watchdog
	initial begin
		#(4 * 30000000);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		frame_plan_t rp;
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		first_pixel = '0;
		second_pixel = '0;
		pad_item = 1'b0;
		out_stall = 1'b0;
		fail_cnt = 0;
		items_sent = 0;
		pads_sent = 0;
		results_seen = 0;
		nonzero_seen = 0;
		phase_cnt = 0;
		burst_left = 0;
		steady_feed = 1'b1;
		stall_mode = 0;
		hold_req = 1'b0;
		// register defaults after reset
		mir_range = 60;
		mir_side = 0;
		mir_width = 427;
		mir_height = 370;
		wr_pos = 0;
		pend_cnt = 0;
		in_col = 0;
		in_row = 0;
		out_idx = 0;
		for (i = 0; i < RING; i++)
			line_ring[i] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults read back, typed in
		reg_check(REG_RANGE, 60, 32'h7F);
		reg_check(REG_SIDE, 0, 32'h1);
		reg_check(REG_WIDTH, 427, 32'h3FF);
		reg_check(REG_HEIGHT, 370, 32'h3FF);
		// pad at a frame start with nothing pending: no result
		send_item(8'hFF, 8'h00, 1'b1);
		stop_feed();

		// directed part, steady and paced feed by turns
		foreach (plan_table[i]) begin
			steady_feed = (i % 2 == 0);
			stall_mode = i % 3;
			run_phase(plan_table[i]);
		end

		// random part
		while (items_sent < 1400) begin
			rp.side = $urandom_range(0, 1);
			if ($urandom_range(0, 7) == 0) begin
				rp.width = $urandom_range(7, 9);
				rp.range = $urandom_range(11, 64);
			end else begin
				rp.width = $urandom_range(7, 16);
				rp.range = $urandom_range(1, 10);
			end
			rp.height = $urandom_range(7, 10);
			rp.frames = $urandom_range(1, 2);
			case ($urandom_range(0, 19))
				0, 1, 2: rp.pat = PAT_NOISE;
				3, 4, 5: rp.pat = PAT_PADMID;
				default: rp.pat = PAT_SHIFT;
			endcase
			steady_feed = ($urandom_range(0, 3) == 0);
			stall_mode = $urandom_range(0, 2);
			// the first random phase runs into a long receiver hold-off
			if (phase_cnt == plan_table.size()) begin
				steady_feed = 1'b1;
				hold_req = 1'b1;
			end
			run_phase(rp);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		$display("covered %0d phases, %0d transfers in (%0d pads), %0d results out",
			phase_cnt, items_sent, pads_sent, results_seen);
		$display("%0d results with nonzero disparity, %0d failures", nonzero_seen, fail_cnt);
		if (fail_cnt == 0 && match_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
